@@ sv/ibd_pkg.sv @@
package ibd_pkg;

  // Dimension and palette sizing
  localparam int DimBits      = 16;
  localparam int PixW         = 2 * DimBits;
  localparam int PaletteDepth = 256;
  localparam int PalAw        = $clog2(PaletteDepth);
  localparam int RgbW         = 24;
  localparam int CntW         = 10;

  // Palette sizes in entries for the two depths
  localparam int PalEntries4  = 16;
  localparam int PalEntries8  = 256;

  // Header constants
  localparam logic [7:0] MagicFirst  = 8'h4F;  // 'O'
  localparam logic [7:0] MagicSecond = 8'h49;  // 'I'
  localparam logic [7:0] FileVersion = 8'h04;
  localparam logic [7:0] DepthFour   = 8'd4;
  localparam logic [7:0] DepthEight  = 8'd8;
  localparam logic [CntW-1:0] HeaderLast = CntW'(7);

  typedef enum logic [1:0] {
    PhHeader,
    PhPalette,
    PhPixels,
    PhDone
  } ibd_phase_e;

  typedef enum logic [2:0] {
    ErrTooSmall     = 3'd0,
    ErrBadMagic     = 3'd1,
    ErrBadVersion   = 3'd2,
    ErrBadDepth     = 3'd3,
    ErrShortPalette = 3'd4,
    ErrShortPixels  = 3'd5
  } ibd_err_e;

  // Results owed for one accepted byte: pixels first, then an optional error
  typedef struct packed {
    logic [1:0] npix;
    logic [7:0] idx0;
    logic [7:0] idx1;
    logic       done_last;
    logic       has_err;
    ibd_err_e   code;
  } ibd_job_t;

  // Expand RGB565 to RGB888 as c * 255 / max, truncating.
  // c * 255 / 31 = 8c + floor(7c / 31); c * 255 / 63 = 4g + floor(3g / 63)
  function automatic logic [RgbW-1:0] expand565(logic [15:0] w);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    logic [7:0] r7;
    logic [7:0] g3;
    logic [7:0] b7;
    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    r5 = w[15:11];
    g6 = w[10:5];
    b5 = w[4:0];
    r7 = {3'b000, r5} * 8'd7;
    g3 = {2'b00, g6} * 8'd3;
    b7 = {3'b000, b5} * 8'd7;
    r8 = {r5, 3'b000};
    g8 = {g6, 2'b00};
    b8 = {b5, 3'b000};
    for (int k = 1; k <= 7; k++) begin
      if (r7 >= 8'(31 * k)) r8 = r8 + 8'd1;
      if (b7 >= 8'(31 * k)) b8 = b8 + 8'd1;
    end
    for (int k = 1; k <= 3; k++) begin
      if (g3 >= 8'(63 * k)) g8 = g8 + 8'd1;
    end
    return {r8, g8, b8};
  endfunction

endpackage

@@ sv/ibd_palette_ram.sv @@
module ibd_palette_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ibd_pkg::PalAw-1:0] waddr_i,
  input  logic [ibd_pkg::RgbW-1:0]  wdata_i,
  input  logic                      re_i,
  input  logic [ibd_pkg::PalAw-1:0] raddr_i,
  output logic [ibd_pkg::RgbW-1:0]  rdata_o
);
  import ibd_pkg::*;

  logic [RgbW-1:0] mem_q [PaletteDepth];
  logic [RgbW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/indexed_bitmap_decoder_core.sv @@
// Indexed bitmap decoder. Takes an image file one byte per request: an 8-byte
// header ('O','I', version 4, depth 4 or 8, width and height little-endian),
// then 16 or 256 RGB565 palette words, which are expanded to RGB888 and kept
// in an on-chip palette memory, then packed pixel indices, high nibble first
// at depth 4. Each pixel comes out as RGB888 with alpha 0 for index 0 and 255
// otherwise; image_complete marks the final pixel and last_of_run the last
// result of each input byte. Header faults are reported on the eighth byte
// (the first faulty byte decides the code), cut-off data on the end-of-data
// byte, after any pixels that byte still carries. After completion or an
// error every byte is swallowed until reset. Rate: header and palette bytes
// are taken one per cycle; pixel results are issued one per cycle while the
// output does not stall, and a new byte is taken only as the last result of
// the one before is issued, because every result makes one pass through the
// single read port of the palette memory. Each result passes through the job
// register and then the output stage, aligned with the registered palette
// read. The palette memory needs no clearing pass after reset.
module indexed_bitmap_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [7:0] alpha_o,
  output logic       is_error_o,
  output logic [2:0] error_code_o,
  output logic       image_complete_o,
  output logic       last_of_run_o
);
  import ibd_pkg::*;

  // Decoder state
  ibd_phase_e          phase_q, phase_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                depth8_q, depth8_d;
  logic [15:0]         width_q, width_d;
  logic [7:0]          height_lo_q, height_lo_d;
  logic [PixW-1:0]     pix_left_q, pix_left_d;
  logic [7:0]          pal_lo_q, pal_lo_d;
  logic                hdr_err_vld_q, hdr_err_vld_d;
  ibd_err_e            hdr_err_q, hdr_err_d;

  // Header checks
  logic                fault;
  ibd_err_e            fault_code;
  logic [DimBits-1:0]  dim_w;
  logic [DimBits-1:0]  dim_h;
  logic [CntW-1:0]     pal_last;
  logic                pix_done0;
  logic                pix_done1;

  // Palette memory ports
  logic                pal_we;
  logic [CntW-2:0]     pal_entry;
  logic [RgbW-1:0]     pal_wdata;
  logic                pal_re;
  logic [PalAw-1:0]    pal_raddr;
  logic [RgbW-1:0]     pal_rdata;

  // Result queue of one job
  ibd_job_t            job_q, job_d, job_new;
  logic                job_vld_q, job_vld_d;
  logic                job_new_vld;
  logic [1:0]          job_rem;
  logic                issue;
  logic                iss_pix;
  logic                iss_last;
  logic                iss_in_range;
  logic                in_acc;

  // Output stage
  logic                out_vld_q;
  logic                is_err_q;
  ibd_err_e            err_code_q;
  logic                done_q;
  logic                last_q;
  logic                nz_q;
  logic                zero_q;

  assign in_acc    = in_valid_i & in_ready_o;
  assign pal_entry = cnt_q[CntW-1:1];
  assign pal_wdata = expand565({data_byte_i, pal_lo_q});
  assign dim_w     = width_q[DimBits-1:0];
  assign dim_h     = DimBits'({data_byte_i, height_lo_q});
  assign pal_last  = depth8_q ? CntW'(2 * PalEntries8 - 1) : CntW'(2 * PalEntries4 - 1);
  assign pix_done0 = (pix_left_q == PixW'(1));
  assign pix_done1 = (pix_left_q == PixW'(2));

  // Decode one accepted byte: next state, palette write and owed results
  always_comb begin
    phase_d       = phase_q;
    cnt_d         = cnt_q;
    depth8_d      = depth8_q;
    width_d       = width_q;
    height_lo_d   = height_lo_q;
    pix_left_d    = pix_left_q;
    pal_lo_d      = pal_lo_q;
    hdr_err_vld_d = hdr_err_vld_q;
    hdr_err_d     = hdr_err_q;
    fault         = 1'b0;
    fault_code    = ErrTooSmall;
    pal_we        = 1'b0;
    job_new       = '0;
    job_new_vld   = 1'b0;
    if (in_acc) begin
      case (phase_q)
        PhHeader: begin
          if (cnt_q == CntW'(0) && data_byte_i != MagicFirst) begin
            fault      = 1'b1;
            fault_code = ErrBadMagic;
          end
          if (cnt_q == CntW'(1) && data_byte_i != MagicSecond) begin
            fault      = 1'b1;
            fault_code = ErrBadMagic;
          end
          if (cnt_q == CntW'(2) && data_byte_i != FileVersion) begin
            fault      = 1'b1;
            fault_code = ErrBadVersion;
          end
          if (cnt_q == CntW'(3)) begin
            if (data_byte_i == DepthEight) begin
              depth8_d = 1'b1;
            end else if (data_byte_i == DepthFour) begin
              depth8_d = 1'b0;
            end else begin
              fault      = 1'b1;
              fault_code = ErrBadDepth;
            end
          end
          if (fault && !hdr_err_vld_q) begin
            hdr_err_vld_d = 1'b1;
            hdr_err_d     = fault_code;
          end
          if (cnt_q == CntW'(4)) width_d[7:0]  = data_byte_i;
          if (cnt_q == CntW'(5)) width_d[15:8] = data_byte_i;
          if (cnt_q == CntW'(6)) height_lo_d   = data_byte_i;
          if (cnt_q >= HeaderLast) begin
            if (hdr_err_vld_d) begin
              job_new_vld     = 1'b1;
              job_new.has_err = 1'b1;
              job_new.code    = hdr_err_d;
              phase_d         = PhDone;
            end else begin
              pix_left_d = PixW'(dim_w) * PixW'(dim_h);
              cnt_d      = '0;
              phase_d    = PhPalette;
              if (end_of_data_i) begin
                job_new_vld     = 1'b1;
                job_new.has_err = 1'b1;
                job_new.code    = ErrShortPalette;
                phase_d         = PhDone;
              end
            end
          end else if (end_of_data_i) begin
            job_new_vld     = 1'b1;
            job_new.has_err = 1'b1;
            job_new.code    = ErrTooSmall;
            phase_d         = PhDone;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
        PhPalette: begin
          if (!cnt_q[0]) begin
            pal_lo_d = data_byte_i;
          end else begin
            pal_we = ({1'b0, pal_entry} < CntW'(PaletteDepth));
          end
          if (cnt_q >= pal_last) begin
            if (pix_left_q == '0) begin
              phase_d = PhDone;
            end else if (end_of_data_i) begin
              job_new_vld     = 1'b1;
              job_new.has_err = 1'b1;
              job_new.code    = ErrShortPixels;
              phase_d         = PhDone;
            end else begin
              phase_d = PhPixels;
            end
          end else if (end_of_data_i) begin
            job_new_vld     = 1'b1;
            job_new.has_err = 1'b1;
            job_new.code    = ErrShortPalette;
            phase_d         = PhDone;
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
        PhPixels: begin
          job_new_vld  = 1'b1;
          job_new.code = ErrShortPixels;
          if (depth8_q) begin
            job_new.npix      = 2'd1;
            job_new.idx0      = data_byte_i;
            job_new.done_last = pix_done0;
            pix_left_d        = pix_left_q - PixW'(1);
          end else begin
            job_new.npix      = pix_done0 ? 2'd1 : 2'd2;
            job_new.idx0      = {4'h0, data_byte_i[7:4]};
            job_new.idx1      = {4'h0, data_byte_i[3:0]};
            job_new.done_last = pix_done0 | pix_done1;
            pix_left_d        = pix_left_q - (pix_done0 ? PixW'(1) : PixW'(2));
          end
          job_new.has_err = end_of_data_i & ~job_new.done_last;
          if (job_new.done_last || end_of_data_i) begin
            phase_d = PhDone;
          end
        end
        default: ;
      endcase
    end
  end

  // Hold decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhHeader;
      cnt_q         <= '0;
      depth8_q      <= 1'b0;
      width_q       <= '0;
      height_lo_q   <= '0;
      pix_left_q    <= '0;
      pal_lo_q      <= '0;
      hdr_err_vld_q <= 1'b0;
      hdr_err_q     <= ErrTooSmall;
    end else begin
      phase_q       <= phase_d;
      cnt_q         <= cnt_d;
      depth8_q      <= depth8_d;
      width_q       <= width_d;
      height_lo_q   <= height_lo_d;
      pix_left_q    <= pix_left_d;
      pal_lo_q      <= pal_lo_d;
      hdr_err_vld_q <= hdr_err_vld_d;
      hdr_err_q     <= hdr_err_d;
    end
  end

  // Issue one result per cycle from the pending job while the output can take it
  assign job_rem      = job_q.npix + 2'(job_q.has_err);
  assign issue        = job_vld_q & (~out_vld_q | out_ready_i);
  assign iss_pix      = (job_q.npix != 2'd0);
  assign iss_last     = (job_rem == 2'd1);
  assign iss_in_range = ({1'b0, job_q.idx0} < 9'(PaletteDepth));
  assign in_ready_o   = ~job_vld_q | (issue & iss_last);
  assign pal_re       = issue & iss_pix & iss_in_range;
  assign pal_raddr    = PalAw'(job_q.idx0);

  // Advance the job: drop issued results, load a new request's results
  always_comb begin
    job_d     = job_q;
    job_vld_d = job_vld_q;
    if (issue) begin
      if (iss_last) begin
        job_vld_d = 1'b0;
      end else if (iss_pix) begin
        job_d.npix = job_q.npix - 2'd1;
        job_d.idx0 = job_q.idx1;
      end else begin
        job_d.has_err = 1'b0;
      end
    end
    if (in_acc && job_new_vld) begin
      job_d     = job_new;
      job_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_vld_q <= 1'b0;
    end else begin
      job_vld_q <= job_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  ibd_palette_ram u_palette_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_entry[PalAw-1:0]),
    .wdata_i (pal_wdata),
    .re_i    (pal_re),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  // Output stage: valid flag, plus result tags aligned with the palette read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (issue) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      is_err_q   <= ~iss_pix;
      err_code_q <= iss_pix ? ErrTooSmall : job_q.code;
      done_q     <= iss_pix & (job_q.npix == 2'd1) & job_q.done_last;
      last_q     <= iss_last;
      nz_q       <= iss_pix & (job_q.idx0 != 8'd0);
      zero_q     <= ~iss_pix | ~iss_in_range;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign red_o            = zero_q ? 8'd0 : pal_rdata[23:16];
  assign green_o          = zero_q ? 8'd0 : pal_rdata[15:8];
  assign blue_o           = zero_q ? 8'd0 : pal_rdata[7:0];
  assign alpha_o          = nz_q ? 8'hFF : 8'h00;
  assign is_error_o       = is_err_q;
  assign error_code_o     = err_code_q;
  assign image_complete_o = done_q;
  assign last_of_run_o    = last_q;

endmodule

@@ tb/sv/indexed_bitmap_decoder_core_tb.sv @@
`timescale 1ns / 1ps

module indexed_bitmap_decoder_core_tb;
  import ibd_pkg::*;

  localparam int CycleLimit = 20000;

  // One byte of the image file as offered on the request channel
  typedef struct packed {
    logic [7:0] value;
    logic       eod;
  } file_byte_t;

  // One decoded result, pixel or error
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       is_err;
    logic [2:0] code;
    logic       done;
    logic       last;
  } decoded_t;

  // Ways of breaking the file early, before any pixel is owed
  typedef enum int {
    FkShortHeader,
    FkBadMagic,
    FkBadVersion,
    FkBadDepth,
    FkManyFaults,
    FkShortPalette,
    FkPaletteAtEnd,
    FkEmptyImage
  } fault_kind_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_data = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       is_error;
  logic [2:0] error_code;
  logic       image_complete;
  logic       last_of_run;

  file_byte_t file_bytes_q[$];
  decoded_t   decoded_q[$];
  int         bytes_taken = 0;
  int         fails = 0;
  int         cycle_count = 0;
  logic       calm;

  // Decoder state kept by the testbench
  ibd_phase_e     dec_phase = PhHeader;
  int unsigned    dec_pos = 0;
  logic           dec_d8 = 1'b0;
  logic [15:0]    img_w = '0;
  logic [15:0]    img_h = '0;
  logic [31:0]    px_left = '0;
  logic [7:0]     pal_lo = '0;
  logic           hdr_bad = 1'b0;
  ibd_err_e       hdr_code = ErrTooSmall;
  logic [RgbW-1:0] pal_mem [PaletteDepth];

  indexed_bitmap_decoder_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .data_byte_i     (data_byte),
    .end_of_data_i   (end_of_data),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .red_o           (red),
    .green_o         (green),
    .blue_o          (blue),
    .alpha_o         (alpha),
    .is_error_o      (is_error),
    .error_code_o    (error_code),
    .image_complete_o(image_complete),
    .last_of_run_o   (last_of_run)
  );

  always #5 clk = ~clk;

  // No idling on either side through the middle of the file
  assign calm = (bytes_taken >= 30) && (bytes_taken < 75);

  // Widen RGB565 to RGB888, each channel scaled by 255 over its maximum
  function automatic logic [RgbW-1:0] widen565(input logic [15:0] w);
    int r;
    int g;
    int bl;
    r  = (int'(w[15:11]) * 255) / 31;
    g  = (int'(w[10:5]) * 255) / 63;
    bl = (int'(w[4:0]) * 255) / 31;
    return {r[7:0], g[7:0], bl[7:0]};
  endfunction

  function automatic logic [7:0] other_than(input logic [7:0] v);
    logic [7:0] r;
    r = 8'($urandom);
    if (r == v) r = ~v;
    return r;
  endfunction

  // Keep only the first header fault
  task automatic note_fault(input ibd_err_e c);
    if (!hdr_bad) begin
      hdr_bad  = 1'b1;
      hdr_code = c;
    end
  endtask

  task automatic emit_error(input ibd_err_e c);
    decoded_t res;
    res        = '0;
    res.is_err = 1'b1;
    res.code   = c;
    decoded_q.push_back(res);
    dec_phase = PhDone;
  endtask

  // Work out the results owed for one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic eod);
    int unsigned pos;
    int unsigned total;
    int unsigned slots;
    int unsigned s;
    int unsigned idx;
    int          start;
    decoded_t    res;
    logic [RgbW-1:0] rgb;
    start = decoded_q.size();
    pos   = dec_pos % 1024;
    case (dec_phase)
      PhHeader: begin
        if (pos == 0 && b != MagicFirst) note_fault(ErrBadMagic);
        if (pos == 1 && b != MagicSecond) note_fault(ErrBadMagic);
        if (pos == 2 && b != FileVersion) note_fault(ErrBadVersion);
        if (pos == 3) begin
          if (b == DepthEight) dec_d8 = 1'b1;
          else if (b == DepthFour) dec_d8 = 1'b0;
          else note_fault(ErrBadDepth);
        end
        if (pos == 4) img_w[7:0] = b;
        if (pos == 5) img_w[15:8] = b;
        if (pos == 6) img_h[7:0] = b;
        if (pos == 7) img_h[15:8] = b;
        if (pos >= 7) begin
          if (hdr_bad) begin
            emit_error(hdr_code);
          end else begin
            // dimensions are already DimBits wide
            px_left   = 32'(img_w) * 32'(img_h);
            dec_pos   = 0;
            dec_phase = PhPalette;
            if (eod) emit_error(ErrShortPalette);
          end
        end else if (eod) begin
          emit_error(ErrTooSmall);
        end else begin
          dec_pos = pos + 1;
        end
      end
      PhPalette: begin
        total = dec_d8 ? 2 * PalEntries8 : 2 * PalEntries4;
        if (pos % 2 == 0) pal_lo = b;
        else if ((pos >> 1) < PaletteDepth) pal_mem[pos >> 1] = widen565({b, pal_lo});
        if (pos + 1 >= total) begin
          if (px_left == 0) dec_phase = PhDone;
          else if (eod) emit_error(ErrShortPixels);
          else dec_phase = PhPixels;
        end else if (eod) begin
          emit_error(ErrShortPalette);
        end else begin
          dec_pos = pos + 1;
        end
      end
      PhPixels: begin
        slots = dec_d8 ? 1 : 2;
        for (s = 0; s < slots && dec_phase == PhPixels; s++) begin
          if (dec_d8) idx = b;
          else if (s == 0) idx = b[7:4];
          else idx = b[3:0];
          rgb       = (idx < PaletteDepth) ? pal_mem[idx] : '0;
          px_left   = px_left - 1;
          res       = '0;
          res.red   = rgb[23:16];
          res.green = rgb[15:8];
          res.blue  = rgb[7:0];
          res.alpha = (idx == 0) ? 8'h00 : 8'hFF;
          res.done  = (px_left == 0);
          decoded_q.push_back(res);
          if (px_left == 0) dec_phase = PhDone;
        end
        if (dec_phase == PhPixels && eod) emit_error(ErrShortPixels);
      end
      default: ;
    endcase
    if (decoded_q.size() > start) decoded_q[decoded_q.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (fails < 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fails++;
    end
  endtask

  task automatic push_byte(input logic [7:0] v, input logic e);
    file_byte_t req;
    req.value = v;
    req.eod   = e;
    file_bytes_q.push_back(req);
  endtask

  // Queue header bytes up to and including eod_at; 8 or more means no end
  task automatic push_header(input logic [7:0] m0, input logic [7:0] m1,
                             input logic [7:0] ver, input logic [7:0] dep,
                             input logic [15:0] w, input logic [15:0] h,
                             input int eod_at);
    logic [7:0] hdr [8];
    hdr[0] = m0;
    hdr[1] = m1;
    hdr[2] = ver;
    hdr[3] = dep;
    hdr[4] = w[7:0];
    hdr[5] = w[15:8];
    hdr[6] = h[7:0];
    hdr[7] = h[15:8];
    for (int i = 0; i < 8 && i <= eod_at; i++) push_byte(hdr[i], i == eod_at);
  endtask

  // Palette words, the channel extremes first
  task automatic push_palette(input int n, input logic eod_last);
    logic [15:0] word;
    word = '0;
    for (int i = 0; i < n; i++) begin
      if (i % 2 == 0) begin
        case (i / 2)
          0:       word = 16'h0000;
          1:       word = 16'hFFFF;
          2:       word = 16'hF800;
          3:       word = 16'h07E0;
          4:       word = 16'h001F;
          5:       word = 16'h0821;
          default: word = 16'($urandom);
        endcase
        push_byte(word[7:0], eod_last && i == n - 1);
      end else begin
        push_byte(word[15:8], eod_last && i == n - 1);
      end
    end
  endtask

  task automatic push_pixels(input logic d8, input int n, input logic eod_last);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      case (i)
        0:       v = 8'h00;
        1:       v = 8'hFF;
        2:       v = d8 ? 8'h01 : 8'h0F;
        3:       v = d8 ? 8'h80 : 8'hF0;
        default: v = 8'($urandom);
      endcase
      push_byte(v, eod_last && i == n - 1);
    end
  endtask

  // Build the file, release reset, then wait for the decoder to drain
  initial begin : stimulus
    int          pick;
    int          w;
    int          h;
    int          nbytes;
    int          total;
    logic        d8;
    logic [7:0]  dep;
    fault_kind_e kind;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      // well-formed header and palette; depth 8 for a tenth, huge sizes for a few
      d8 = (pick >= 70) && (pick < 80);
      if (pick >= 80) begin
        w = $urandom_range(0, 1) ? 65535 : $urandom_range(256, 65535);
        h = $urandom_range(0, 1) ? 65535 : $urandom_range(256, 65535);
      end else if (d8) begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end else begin
        w = $urandom_range(1, 16);
        h = ($urandom_range(100, 140) + w - 1) / w;
      end
      push_header(MagicFirst, MagicSecond, FileVersion, d8 ? DepthEight : DepthFour,
                  16'(w), 16'(h), 8);
      push_palette(d8 ? 2 * PalEntries8 : 2 * PalEntries4, 1'b0);
      if (pick >= 80) begin
        push_pixels(d8, 70, 1'b1);
      end else begin
        nbytes = d8 ? w * h : (w * h + 1) / 2;
        if (nbytes > 1 && ((pick >= 50 && pick < 70) || (d8 && $urandom_range(0, 1))))
          push_pixels(d8, $urandom_range(1, nbytes - 1), 1'b1);
        else
          push_pixels(d8, nbytes, 1'($urandom_range(0, 1)));
      end
    end else begin
      kind  = fault_kind_e'($urandom_range(0, 7));
      d8    = 1'($urandom_range(0, 1));
      dep   = d8 ? DepthEight : DepthFour;
      total = d8 ? 2 * PalEntries8 : 2 * PalEntries4;
      case (kind)
        FkShortHeader: begin
          push_header(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom), $urandom_range(0, 6));
        end
        FkBadMagic: begin
          if ($urandom_range(0, 1))
            push_header(other_than(MagicFirst), MagicSecond, FileVersion, dep,
                        16'($urandom), 16'($urandom), $urandom_range(7, 8));
          else
            push_header(MagicFirst, other_than(MagicSecond), FileVersion, dep,
                        16'($urandom), 16'($urandom), $urandom_range(7, 8));
        end
        FkBadVersion: begin
          push_header(MagicFirst, MagicSecond, other_than(FileVersion), dep,
                      16'($urandom), 16'($urandom), $urandom_range(7, 8));
        end
        FkBadDepth: begin
          dep = other_than(DepthFour);
          if (dep == DepthEight) dep = 8'h00;
          push_header(MagicFirst, MagicSecond, FileVersion, dep,
                      16'($urandom), 16'($urandom), $urandom_range(7, 8));
        end
        FkManyFaults: begin
          push_header(other_than(MagicFirst), 8'($urandom), 8'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom), 8);
        end
        FkShortPalette: begin
          if ($urandom_range(0, 3) == 0) begin
            push_header(MagicFirst, MagicSecond, FileVersion, dep,
                        16'($urandom), 16'($urandom), 7);
          end else begin
            push_header(MagicFirst, MagicSecond, FileVersion, dep,
                        16'($urandom), 16'($urandom), 8);
            push_palette($urandom_range(1, total - 1), 1'b1);
          end
        end
        FkPaletteAtEnd: begin
          push_header(MagicFirst, MagicSecond, FileVersion, dep,
                      16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 8);
          push_palette(total, 1'b1);
        end
        default: begin
          // empty image: one dimension zero, the other anything
          w = $urandom_range(0, 65535);
          if ($urandom_range(0, 1))
            push_header(MagicFirst, MagicSecond, FileVersion, dep, 16'(w), 16'h0000, 8);
          else
            push_header(MagicFirst, MagicSecond, FileVersion, dep, 16'h0000, 16'(w), 8);
          push_palette(total, 1'($urandom_range(0, 1)));
        end
      endcase
    end
    // trailing bytes, all to be swallowed
    for (int i = 0; i < 8; i++) push_byte(8'($urandom), 1'($urandom_range(0, 1)));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (file_bytes_q.size() != 0 || in_valid) @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Offer the next file byte; hold it until taken
  always @(posedge clk) begin
    file_byte_t req;
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (file_bytes_q.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          req = file_bytes_q.pop_front();
          in_valid    <= 1'b1;
          data_byte   <= req.value;
          end_of_data <= req.eod;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Predict on every accepted request, then check every accepted result
  always @(posedge clk) begin
    decoded_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_byte(data_byte, end_of_data);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with nothing owed, error %0b code %0d rgba %h%h%h%h",
                   $time, is_error, error_code, red, green, blue, alpha);
          fails++;
        end else begin
          want = decoded_q.pop_front();
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
          check_field("alpha", want.alpha, alpha);
          check_field("is_error", want.is_err, is_error);
          check_field("error_code", want.code, error_code);
          check_field("image_complete", want.done, image_complete);
          check_field("last_of_run", want.last, last_of_run);
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  // Give up on a hung decoder
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
